// ----- src/fbpa_pkg.sv -----
// Shared constants, codes and types of the fixed block pool allocator.
`default_nettype none

package fbpa_pkg;

    // Field widths of the request, result and register interface.
    localparam int C_ADDR_W     = 32;
    localparam int C_SIZE_W     = 16;
    localparam int C_CNT_W      = 7;
    localparam int C_ALIGN_W    = 13;
    localparam int C_ACT_W      = 2;
    localparam int C_STAT_W     = 3;
    localparam int C_DATA_W     = 32;
    localparam int C_PADDR_W    = 4;
    localparam int C_PROD_W     = C_CNT_W + C_SIZE_W;

    // Width of the address space that fresh block addresses wrap to.
    localparam int C_ADDR_WIDTH = 32;

    // Request actions.
    localparam logic [C_ACT_W-1:0] ACT_ALLOC  = 2'd0;
    localparam logic [C_ACT_W-1:0] ACT_FREE   = 2'd1;
    localparam logic [C_ACT_W-1:0] ACT_RESIZE = 2'd2;

    // Result status codes.
    localparam logic [C_STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [C_STAT_W-1:0] ST_ZERO    = 3'd1;
    localparam logic [C_STAT_W-1:0] ST_ALLOC   = 3'd2;
    localparam logic [C_STAT_W-1:0] ST_FREE    = 3'd3;
    localparam logic [C_STAT_W-1:0] ST_CORRUPT = 3'd4;

    // Register indexes (word address on the configuration port).
    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_BSIZE = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;
    localparam logic [1:0] REG_ALIGN = 2'd3;

    // One free stack entry as it moves between neighboring cells.
    typedef struct packed {
        logic                valid;
        logic [C_ADDR_W-1:0] data;
    } t_entry;

    // Shift control broadcast to every cell of the stack.
    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_ctl;

    // Status of the alignment remainder unit.
    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_mod_stat;

endpackage

`default_nettype wire

// ----- src/fbpa_cell.sv -----
// One cell of the free stack: holds one entry, shifts on push and pop, and
// passes the double-free match flag on to its neighbor.
`default_nettype none

module fbpa_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fbpa_pkg::t_stk_ctl             i_ctl,
    input  fbpa_pkg::t_entry               i_prev,
    input  fbpa_pkg::t_entry               i_next,
    input  logic [fbpa_pkg::C_ADDR_W-1:0]  i_cmp_addr,
    input  logic                           i_hit,
    output fbpa_pkg::t_entry               o_entry,
    output logic                           o_hit
);
    import fbpa_pkg::*;

    logic                r_valid;
    logic [C_ADDR_W-1:0] r_data;
    logic                r_hit;
    logic                n_valid;
    logic [C_ADDR_W-1:0] n_data;

    // A push takes the entry from the cell above, a pop the one from below.
    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_ctl.push) begin
            n_valid = i_prev.valid;
            n_data  = i_prev.data;
        end else if (i_ctl.pop) begin
            n_valid = i_next.valid;
            n_data  = i_next.data;
        end
    end

    // The match flag accumulates one cell further down the row each cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_hit   <= i_hit | (r_valid && (r_data == i_cmp_addr));
        end
    end

    // Entry data needs no reset; the valid bit qualifies it.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_entry.valid = r_valid;
    assign o_entry.data  = r_data;
    assign o_hit         = r_hit;

endmodule

`default_nettype wire

// ----- src/fbpa_mod.sv -----
// Bit-serial remainder unit used for the alignment check of a free request.
`default_nettype none

module fbpa_mod (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [fbpa_pkg::C_ADDR_W-1:0]   i_dividend,
    input  logic [fbpa_pkg::C_ALIGN_W-1:0]  i_divisor,
    output fbpa_pkg::t_mod_stat             o_stat
);
    import fbpa_pkg::*;

    localparam int STEP_W = $clog2(C_ADDR_W + 1);

    logic [STEP_W-1:0]    r_cnt;
    logic [C_ADDR_W-1:0]  r_dvd;
    logic [C_ALIGN_W-1:0] r_div;
    logic [C_ALIGN_W-1:0] r_rem;
    logic [C_ALIGN_W-1:0] n_rem;
    logic [C_ALIGN_W:0]   w_trial;
    logic [C_ALIGN_W:0]   w_diff;

    // Restoring step: bring in the next dividend bit, subtract if it fits.
    always_comb begin
        w_trial = {r_rem, r_dvd[C_ADDR_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = w_diff[C_ALIGN_W-1:0];
        end else begin
            n_rem = w_trial[C_ALIGN_W-1:0];
        end
    end

    // Step counter: one dividend bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= STEP_W'(C_ADDR_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Datapath; a zero alignment acts as one, so every address passes.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= (i_divisor == '0) ? C_ALIGN_W'(1) : i_divisor;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[C_ADDR_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_stat.done     = (r_cnt == '0);
    assign o_stat.rem_zero = (r_rem == '0);

endmodule

`default_nettype wire

// ----- src/fixed_block_pool_allocator.sv -----
// Fixed block pool allocator: a pool of equal blocks with a LIFO free stack.
//
// A request on the input channel (i_valid / o_ready) carries an action, a
// size and an address; each request gives exactly one result on the output
// channel (o_valid / i_ready): a status, a granted address and a size.
// Allocate takes the most recently freed block from the free stack, or hands
// out the next fresh block base + used * size. Free checks alignment, range
// and double free, then lowers the used count or pushes the block.
// The free stack is a row of min(MAX_BLOCKS, 127) cells.
// Allocate and resize pass through the multiply stage before their result;
// a free also waits until the double-free match flag has walked the cell
// row one cell per cycle and the alignment remainder has been formed one
// address bit per cycle.
// Requests are taken only while no request is in work; a finished result
// waits in the output register while the next request is accepted.
// A stalled receiver holds the result; the block then waits before it
// writes the next one. Reset empties the pool and restores the registers
// (base 0, block size 1, block count 64, alignment 1); no clearing pass.
// User configuration via the APB-style port must wait for idle; not enforced.
`default_nettype none

module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Request channel
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [fbpa_pkg::C_ACT_W-1:0]     i_action,
    input  logic [fbpa_pkg::C_SIZE_W-1:0]    i_request_size,
    input  logic [fbpa_pkg::C_ADDR_W-1:0]    i_address,
    // Result channel
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [fbpa_pkg::C_STAT_W-1:0]    o_status,
    output logic [fbpa_pkg::C_ADDR_W-1:0]    o_granted_address,
    output logic [fbpa_pkg::C_SIZE_W-1:0]    o_granted_size,
    // Configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fbpa_pkg::C_PADDR_W-1:0]   paddr,
    input  logic [fbpa_pkg::C_DATA_W-1:0]    pwdata,
    output logic [fbpa_pkg::C_DATA_W-1:0]    prdata,
    output logic                             pready
);
    import fbpa_pkg::*;

    // Counts never exceed 127, so cells past that never hold an entry.
    localparam int NCELL  = (MAX_BLOCKS < 127) ? MAX_BLOCKS : 127;
    localparam int SCAN_W = $clog2(NCELL + 1);
    localparam logic [C_CNT_W-1:0] L_MAX_CNT = C_CNT_W'(NCELL);
    localparam logic [C_ADDR_W-1:0] L_AMASK  = (C_ADDR_WIDTH >= C_ADDR_W) ? '1 :
        C_ADDR_W'((64'd1 << C_ADDR_WIDTH) - 64'd1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_WAIT,
        S_FIN
    } t_state;

    // Configuration registers
    logic [C_ADDR_W-1:0]  r_base;
    logic [C_SIZE_W-1:0]  r_bsize;
    logic [C_CNT_W-1:0]   r_bcount;
    logic [C_ALIGN_W-1:0] r_align;

    // Control state
    t_state               r_state;
    t_state               n_state;
    logic [C_CNT_W-1:0]   r_used;
    logic [C_CNT_W-1:0]   r_free;
    logic [C_CNT_W-1:0]   n_used;
    logic [C_CNT_W-1:0]   n_free;
    logic [SCAN_W-1:0]    r_scan_cnt;

    // Captured request and products
    logic [C_ACT_W-1:0]   r_act;
    logic [C_SIZE_W-1:0]  r_size;
    logic [C_ADDR_W-1:0]  r_addr;
    logic [C_PROD_W-1:0]  r_prod_fresh;
    logic [C_PROD_W-1:0]  r_prod_end;
    logic [C_PROD_W-1:0]  r_prod_top;

    // Output register
    logic                 r_o_valid;
    logic [C_STAT_W-1:0]  r_o_status;
    logic [C_ADDR_W-1:0]  r_o_addr;
    logic [C_SIZE_W-1:0]  r_o_size;

    logic                 w_take;
    logic                 w_slot;
    logic                 w_commit;
    logic                 w_cfg_wr;
    logic [C_CNT_W-1:0]   w_cnt;
    logic [C_ADDR_W:0]    w_fresh_sum;
    logic [C_ADDR_W:0]    w_end;
    logic [C_ADDR_W:0]    w_top;
    logic                 w_is_top;
    logic                 w_free_err;
    logic                 w_push;
    logic                 w_pop;
    logic [C_STAT_W-1:0]  w_res_status;
    logic [C_ADDR_W-1:0]  w_res_addr;
    logic [C_SIZE_W-1:0]  w_res_size;
    t_mod_stat            w_mod;
    t_stk_ctl             w_ctl;
    t_entry               w_ent [NCELL];
    logic                 w_hit [NCELL];

    // Handshakes
    assign o_ready  = (r_state == S_IDLE);
    assign w_take   = i_valid && o_ready;
    assign w_slot   = !r_o_valid || i_ready;
    assign w_commit = (r_state == S_FIN) && w_slot;
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= '0;
            r_bsize  <= C_SIZE_W'(1);
            r_bcount <= C_CNT_W'(64);
            r_align  <= C_ALIGN_W'(1);
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_BASE:  r_base   <= pwdata[C_ADDR_W-1:0];
                REG_BSIZE: r_bsize  <= pwdata[C_SIZE_W-1:0];
                REG_COUNT: r_bcount <= pwdata[C_CNT_W-1:0];
                REG_ALIGN: r_align  <= pwdata[C_ALIGN_W-1:0];
                default: ;
            endcase
        end
    end

    // Configuration read-back.
    always_comb begin
        case (paddr[3:2])
            REG_BASE:  prdata = r_base;
            REG_BSIZE: prdata = C_DATA_W'(r_bsize);
            REG_COUNT: prdata = C_DATA_W'(r_bcount);
            REG_ALIGN: prdata = C_DATA_W'(r_align);
            default:   prdata = '0;
        endcase
    end

    // Block counts above the cell row act as the row length.
    assign w_cnt = (r_bcount > L_MAX_CNT) ? L_MAX_CNT : r_bcount;

    // Capture the request.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_act  <= i_action;
            r_size <= i_request_size;
            r_addr <= i_address;
        end
    end

    // Multiply stage: fresh block offset, pool end and highest used block.
    always_ff @(posedge i_clk) begin
        if (r_state == S_PREP) begin
            r_prod_fresh <= C_PROD_W'(r_used) * C_PROD_W'(r_bsize);
            r_prod_end   <= C_PROD_W'(w_cnt) * C_PROD_W'(r_bsize);
            r_prod_top   <= C_PROD_W'(C_CNT_W'(r_used - 1'b1)) * C_PROD_W'(r_bsize);
        end
    end

    // Alignment remainder runs alongside the stack scan.
    fbpa_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_take),
        .i_dividend (i_address),
        .i_divisor  (r_align),
        .o_stat     (w_mod)
    );

    // Free stack: cell 0 is the top; the match flag leaves the last cell.
    assign w_ctl.push = w_push;
    assign w_ctl.pop  = w_pop;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        t_entry w_prev;
        t_entry w_next;
        logic   w_hit_in;

        if (k == 0) begin : g_top
            assign w_prev.valid = 1'b1;
            assign w_prev.data  = r_addr;
            assign w_hit_in     = 1'b0;
        end else begin : g_mid
            assign w_prev   = w_ent[k-1];
            assign w_hit_in = w_hit[k-1];
        end

        if (k == NCELL - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_ent[k+1];
        end

        fbpa_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_prev     (w_prev),
            .i_next     (w_next),
            .i_cmp_addr (r_addr),
            .i_hit      (w_hit_in),
            .o_entry    (w_ent[k]),
            .o_hit      (w_hit[k])
        );
    end

    // Address sums are kept one bit wider than the address for range checks.
    assign w_fresh_sum = {1'b0, r_base} + (C_ADDR_W + 1)'(r_prod_fresh);
    assign w_end       = {1'b0, r_base} + (C_ADDR_W + 1)'(r_prod_end);
    assign w_top       = {1'b0, r_base} + (C_ADDR_W + 1)'(r_prod_top);
    assign w_is_top    = (w_top == {1'b0, r_addr});

    // Any failed check of a free gives the same status and changes nothing.
    assign w_free_err = !w_mod.rem_zero || (r_addr < r_base) ||
                        ({1'b0, r_addr} >= w_end) || (r_used == '0) ||
                        w_hit[NCELL-1] || (!w_is_top && (r_free >= w_cnt));

    // Outcome of the request and the counter updates it causes.
    always_comb begin
        w_res_status = ST_ALLOC;
        w_res_addr   = '0;
        w_res_size   = '0;
        n_used       = r_used;
        n_free       = r_free;
        w_push       = 1'b0;
        w_pop        = 1'b0;
        case (r_act)
            ACT_ALLOC: begin
                if (r_size == '0) begin
                    w_res_status = ST_ZERO;
                end else if (r_size > r_bsize) begin
                    w_res_status = ST_ALLOC;
                end else if (!((r_used < w_cnt) || (r_free != '0))) begin
                    w_res_status = ST_ALLOC;
                end else if ((r_used > w_cnt) || (r_free > w_cnt)) begin
                    w_res_status = ST_CORRUPT;
                end else begin
                    w_res_status = ST_OK;
                    w_res_size   = r_bsize;
                    if (r_free == '0) begin
                        w_res_addr = w_fresh_sum[C_ADDR_W-1:0] & L_AMASK;
                        n_used     = r_used + 1'b1;
                    end else begin
                        w_res_addr = w_ent[0].data;
                        n_free     = r_free - 1'b1;
                        w_pop      = w_commit;
                    end
                end
            end
            ACT_FREE: begin
                if (w_free_err) begin
                    w_res_status = ST_FREE;
                end else begin
                    w_res_status = ST_OK;
                    if (w_is_top) begin
                        n_used = r_used - 1'b1;
                    end else begin
                        n_free = r_free + 1'b1;
                        w_push = w_commit;
                    end
                end
            end
            ACT_RESIZE: begin
                if (r_size > r_bsize) begin
                    w_res_status = ST_ALLOC;
                end else begin
                    w_res_status = ST_OK;
                    w_res_size   = r_size;
                end
            end
            default: begin
                w_res_status = ST_ALLOC;
            end
        endcase
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_take) n_state = S_PREP;
            end
            S_PREP: begin
                n_state = (r_act == ACT_FREE) ? S_WAIT : S_FIN;
            end
            S_WAIT: begin
                if ((r_scan_cnt == '0) && w_mod.done) n_state = S_FIN;
            end
            S_FIN: begin
                if (w_slot) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer state, counters and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_used     <= '0;
            r_free     <= '0;
            r_scan_cnt <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_take) begin
                r_scan_cnt <= SCAN_W'(NCELL);
            end else if (r_scan_cnt != '0) begin
                r_scan_cnt <= r_scan_cnt - 1'b1;
            end
            if (w_commit) begin
                r_used     <= n_used;
                r_free     <= n_free;
                r_o_valid  <= 1'b1;
                r_o_status <= w_res_status;
                r_o_addr   <= w_res_addr;
                r_o_size   <= w_res_size;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid           = r_o_valid;
    assign o_status          = r_o_status;
    assign o_granted_address = r_o_addr;
    assign o_granted_size    = r_o_size;

endmodule

`default_nettype wire

// ----- src/fbpa_chk.sv -----
// Port-level checks of the fixed block pool allocator and their binding.
`default_nettype none

module fbpa_chk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_valid,
    input  logic                            i_ready,
    input  logic [fbpa_pkg::C_STAT_W-1:0]   o_status,
    input  logic [fbpa_pkg::C_ADDR_W-1:0]   o_granted_address,
    input  logic [fbpa_pkg::C_SIZE_W-1:0]   o_granted_size
);
    import fbpa_pkg::*;

    // Reset drops any pending result.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) &&
        $stable(o_granted_address) && $stable(o_granted_size))
        else $error("stalled result changed");

    // Only defined status codes are reported.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_ZERO ||
        o_status == ST_ALLOC || o_status == ST_FREE || o_status == ST_CORRUPT))
        else $error("undefined status code");

    // A failed request grants neither an address nor a size.
    a_fail_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |->
        (o_granted_address == '0) && (o_granted_size == '0))
        else $error("failed request carries a grant");

endmodule

bind fixed_block_pool_allocator fbpa_chk u_fbpa_chk (.*);

`default_nettype wire
